### hdl/rfpp_pkg.sv
// Shared types, codes and color scaling functions for the raw frame pixel probe.
`default_nettype none

package rfpp_pkg;

  // Default dimension field width
  localparam int DIM_BITS_DEF = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_X    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_Y    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RGB565_CODE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BGRA_CODE   = 2'd3;

  localparam logic [31:0] RGB565_CODE_RST = 32'd4;
  localparam logic [31:0] BGRA_CODE_RST   = 32'd5;

  // Result status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_OOB    = 3'd1;
  localparam logic [2:0] ST_EOS    = 3'd2;
  localparam logic [2:0] ST_PIXEL  = 3'd3;
  localparam logic [2:0] ST_HEADER = 3'd4;
  localparam logic [2:0] ST_DIM    = 3'd5;

  // Pixel format kinds
  localparam logic [1:0] FMT_RGBA   = 2'd0;
  localparam logic [1:0] FMT_RGB565 = 2'd1;
  localparam logic [1:0] FMT_BGRA   = 2'd2;

  // Reciprocals scaled by 2^20 for exact floor division of c*255
  localparam logic [15:0] RECIP31 = 16'd33826;
  localparam logic [14:0] RECIP63 = 15'd16645;

  typedef struct packed {
    logic [15:0] target_x;
    logic [15:0] target_y;
    logic [31:0] rgb565_code;
    logic [31:0] bgra_code;
  } cfg_t;

  // Parser result before color unpacking
  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  fmt;
    logic [31:0] word;
  } raw_res_t;

  // Final result word
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [2:0] status;
  } pix_res_t;

  // Widen a 5-bit channel: floor(c*255/31)
  function automatic logic [7:0] scale5(input logic [4:0] c);
    logic [12:0] n;
    logic [28:0] p;
    n = {c, 8'b0} - 13'(c);
    p = 29'(n) * 29'(RECIP31);
    return p[27:20];
  endfunction

  // Widen a 6-bit channel: floor(c*255/63)
  function automatic logic [7:0] scale6(input logic [5:0] c);
    logic [13:0] n;
    logic [28:0] p;
    n = {c, 8'b0} - 14'(c);
    p = 29'(n) * 29'(RECIP63);
    return p[27:20];
  endfunction

endpackage

`default_nettype wire

### hdl/rfpp_in_if.sv
// Byte stream channel carrying the frame dump into the probe.
`default_nettype none

interface rfpp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_frame;

  modport source (output valid, output data_byte, output end_of_frame, input ready);
  modport sink   (input valid, input data_byte, input end_of_frame, output ready);
endinterface

`default_nettype wire

### hdl/rfpp_out_if.sv
// Result channel carrying the captured pixel and status out of the probe.
`default_nettype none

interface rfpp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic [2:0] status;

  modport source (output valid, output red, output green, output blue, output alpha,
                  output status, input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  input status, output ready);
endinterface

`default_nettype wire

### hdl/rfpp_hdr_parse.sv
// Header parser, offset counter and pixel byte capture for one frame.
`default_nettype none

module rfpp_hdr_parse #(
  parameter int DIM_BITS = rfpp_pkg::DIM_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              eof_i,
  input  wire rfpp_pkg::cfg_t    cfg_i,
  output logic                   res_valid_o,
  output rfpp_pkg::raw_res_t     res_o
);
  import rfpp_pkg::*;

  localparam int PROD_W = DIM_BITS + 16;
  localparam int SKIP_W = DIM_BITS + 18;

  localparam logic [4:0] HC_WIDTH_END  = 5'd3;
  localparam logic [4:0] HC_HEIGHT_END = 5'd7;
  localparam logic [4:0] HC_FORMAT_END = 5'd11;
  localparam logic [4:0] HC_HDR_END    = 5'd15;

  logic [4:0]          hc_q, hc_d;
  logic [31:0]         hw_q, hw_d;
  logic [DIM_BITS-1:0] fw_q, fw_d;
  logic [DIM_BITS-1:0] fh_q, fh_d;
  logic [1:0]          fmt_q, fmt_d;
  logic [SKIP_W-1:0]   skip_q, skip_d;
  logic [1:0]          idx_q, idx_d;
  logic [31:0]         pix_q, pix_d;
  logic                given_q, given_d;
  logic [PROD_W-1:0]   prod_q;

  logic [31:0]         hw_new;
  logic                dim_ovf;
  logic [SKIP_W-1:0]   base;
  logic [31:0]         merged;
  logic [1:0]          idx_n;
  logic [1:0]          need;

  assign hw_new  = {data_byte_i, hw_q[31:8]};
  assign dim_ovf = |hw_new[31:DIM_BITS];
  assign base    = SKIP_W'(prod_q) + SKIP_W'(cfg_i.target_x);
  assign idx_n   = idx_q + 2'd1;
  assign need    = (fmt_q == FMT_RGB565) ? 2'd2 : 2'd0;

  // Insert the byte into its lane of the pixel word
  always_comb begin
    merged = pix_q;
    case (idx_q)
      2'd0:    merged[7:0]   = data_byte_i;
      2'd1:    merged[15:8]  = data_byte_i;
      2'd2:    merged[23:16] = data_byte_i;
      default: merged[31:24] = data_byte_i;
    endcase
  end

  // Advance the frame state for one accepted byte
  always_comb begin
    hc_d        = hc_q;
    hw_d        = hw_q;
    fw_d        = fw_q;
    fh_d        = fh_q;
    fmt_d       = fmt_q;
    skip_d      = skip_q;
    idx_d       = idx_q;
    pix_d       = pix_q;
    given_d     = given_q;
    res_valid_o = 1'b0;
    res_o       = '{status: ST_OK, fmt: fmt_q, word: merged};
    if (accept_i) begin
      if (!hc_q[4]) begin
        hw_d = hw_new;
        if (hc_q == HC_WIDTH_END || hc_q == HC_HEIGHT_END) begin
          if (dim_ovf) begin
            if (!given_q) begin
              res_valid_o  = 1'b1;
              res_o.status = ST_DIM;
              given_d      = 1'b1;
            end
          end else if (hc_q == HC_WIDTH_END) begin
            fw_d = hw_new[DIM_BITS-1:0];
          end else begin
            fh_d = hw_new[DIM_BITS-1:0];
          end
        end else if (hc_q == HC_FORMAT_END) begin
          if (hw_new == cfg_i.rgb565_code) begin
            fmt_d = FMT_RGB565;
          end else if (hw_new == cfg_i.bgra_code) begin
            fmt_d = FMT_BGRA;
          end else begin
            fmt_d = FMT_RGBA;
          end
        end else if (hc_q == HC_HDR_END && !given_q) begin
          if (32'(cfg_i.target_x) >= 32'(fw_q) || 32'(cfg_i.target_y) >= 32'(fh_q)) begin
            res_valid_o  = 1'b1;
            res_o.status = ST_OOB;
            given_d      = 1'b1;
          end else begin
            skip_d = (fmt_q == FMT_RGB565) ? (base << 1) : (base << 2);
            idx_d  = 2'd0;
            pix_d  = '0;
          end
        end
        hc_d = hc_q + 5'd1;
      end else if (!given_q) begin
        if (skip_q != '0) begin
          skip_d = skip_q - SKIP_W'(1);
        end else begin
          pix_d = merged;
          idx_d = idx_n;
          if (idx_n == need) begin
            res_valid_o = 1'b1;
            given_d     = 1'b1;
          end
        end
      end
      // Close the frame: report if nothing went out, then rearm
      if (eof_i) begin
        if (!given_d) begin
          res_valid_o = 1'b1;
          if (!hc_d[4]) begin
            res_o.status = ST_HEADER;
          end else if (skip_d != '0) begin
            res_o.status = ST_EOS;
          end else begin
            res_o.status = ST_PIXEL;
          end
        end
        hc_d    = '0;
        hw_d    = '0;
        skip_d  = '0;
        idx_d   = '0;
        pix_d   = '0;
        given_d = 1'b0;
      end
    end
  end

  // Hold the row offset product ready for the end of the header
  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(cfg_i.target_y) * PROD_W'(fw_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hc_q    <= '0;
      hw_q    <= '0;
      fw_q    <= '0;
      fh_q    <= '0;
      fmt_q   <= FMT_RGBA;
      skip_q  <= '0;
      idx_q   <= '0;
      pix_q   <= '0;
      given_q <= 1'b0;
    end else begin
      hc_q    <= hc_d;
      hw_q    <= hw_d;
      fw_q    <= fw_d;
      fh_q    <= fh_d;
      fmt_q   <= fmt_d;
      skip_q  <= skip_d;
      idx_q   <= idx_d;
      pix_q   <= pix_d;
      given_q <= given_d;
    end
  end

  // Once reported, a frame stays silent until it is rearmed
  a_one_per_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    given_q |-> !res_valid_o)
    else $error("second result in one frame");

  a_res_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> accept_i)
    else $error("result without an accepted word");

  a_hdr_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hc_q[4] |-> (hc_q[3:0] == 4'd0))
    else $error("header count ran past the header");

  a_rearm_on_eof: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && eof_i) |=> (hc_q == 5'd0 && !given_q))
    else $error("frame not rearmed after last word");

endmodule

`default_nettype wire

### hdl/rfpp_pix_unpack.sv
// Color unpacking of the captured pixel word into RGBA channels.
`default_nettype none

module rfpp_pix_unpack (
  input  wire rfpp_pkg::raw_res_t raw_i,
  output rfpp_pkg::pix_res_t      pix_o
);
  import rfpp_pkg::*;

  logic [15:0] v;

  assign v = raw_i.word[15:0];

  // Pick channels by format; zero them on any error status
  always_comb begin
    pix_o        = '0;
    pix_o.status = raw_i.status;
    if (raw_i.status == ST_OK) begin
      case (raw_i.fmt)
        FMT_RGB565: begin
          pix_o.red   = scale5(v[15:11]);
          pix_o.green = scale6(v[10:5]);
          pix_o.blue  = scale5(v[4:0]);
          pix_o.alpha = 8'hFF;
        end
        FMT_BGRA: begin
          pix_o.red   = raw_i.word[23:16];
          pix_o.green = raw_i.word[15:8];
          pix_o.blue  = raw_i.word[7:0];
          pix_o.alpha = raw_i.word[31:24];
        end
        default: begin
          pix_o.red   = raw_i.word[7:0];
          pix_o.green = raw_i.word[15:8];
          pix_o.blue  = raw_i.word[23:16];
          pix_o.alpha = raw_i.word[31:24];
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/rfpp_out_skid.sv
// Result register with a skid stage in front of the result channel.
`default_nettype none

module rfpp_out_skid (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               res_valid_i,
  input  wire rfpp_pkg::pix_res_t res_i,
  output logic                    room_o,
  rfpp_out_if.source              res_o
);
  import rfpp_pkg::*;

  logic     out_v_q;
  logic     skid_v_q;
  pix_res_t out_q;
  pix_res_t skid_q;
  logic     take;

  assign take   = out_v_q & res_o.ready;
  assign room_o = !skid_v_q;

  assign res_o.valid  = out_v_q;
  assign res_o.red    = out_q.red;
  assign res_o.green  = out_q.green;
  assign res_o.blue   = out_q.blue;
  assign res_o.alpha  = out_q.alpha;
  assign res_o.status = out_q.status;

  // Valid flags: fill the output first, spill into the skid on a stall
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (take) begin
      if (skid_v_q) begin
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= res_valid_i;
      end
    end else if (res_valid_i) begin
      if (!out_v_q) begin
        out_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end
  end

  // Payload follows the same routing
  always_ff @(posedge clk_i) begin
    if (take && skid_v_q) begin
      out_q <= skid_q;
    end else if (res_valid_i && (take || !out_v_q)) begin
      out_q <= res_i;
    end
    if (res_valid_i && out_v_q && !take) begin
      skid_q <= res_i;
    end
  end

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> !skid_v_q)
    else $error("result arrived with skid full");

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid holds a word while output is empty");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && skid_v_q) |=> (out_v_q && !skid_v_q))
    else $error("skid word lost on drain");

endmodule

`default_nettype wire

### hdl/raw_frame_pixel_probe_unit.sv
// Top level of the raw frame pixel probe: config registers, parser, unpack, output stage.
//
// Usage: the frame dump enters on in_i one byte per word, with end_of_frame set on
// the last byte. Each frame opens with a 16-byte little-endian header (width, height,
// format, an ignored color space word). The configured target pixel is located and
// reported on res_o as one word per frame: RGBA with status ok, or an error status
// with all channels zero (errors at the latest on the end_of_frame byte).
// Configuration goes through cfg_we_i/cfg_idx_i/cfg_data_i: 0 target_x, 1 target_y,
// 2 RGB565 format code, 3 BGRA format code. Write it while no frame is in flight.
// Throughput: one byte per cycle while in_i.ready is high; every byte updates counters
// and capture registers in its accept cycle; the row offset product sits in a register.
// Output: a result is captured in the result register, or in the skid word on a stall.
// Stall: a result register plus a one-word skid stage hold results while res_o is
// stalled; in_i.ready drops only once the skid word is occupied.
// Reset: asynchronous, clears the frame state and restores default register values
// (target 0,0; RGB565 code 4; BGRA code 5); no clearing pass is needed.
`default_nettype none

module raw_frame_pixel_probe_unit #(
  parameter int DIM_BITS = rfpp_pkg::DIM_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [rfpp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [rfpp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  rfpp_in_if.sink                              in_i,
  rfpp_out_if.source                           res_o
);
  import rfpp_pkg::*;

  cfg_t     cfg_q;
  logic     accept;
  logic     room;
  logic     raw_valid;
  raw_res_t raw;
  pix_res_t pix;

  assign in_i.ready = room;
  assign accept     = in_i.valid & room;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_x    <= '0;
      cfg_q.target_y    <= '0;
      cfg_q.rgb565_code <= RGB565_CODE_RST;
      cfg_q.bgra_code   <= BGRA_CODE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TARGET_X:    cfg_q.target_x    <= cfg_data_i[15:0];
        REG_TARGET_Y:    cfg_q.target_y    <= cfg_data_i[15:0];
        REG_RGB565_CODE: cfg_q.rgb565_code <= cfg_data_i;
        REG_BGRA_CODE:   cfg_q.bgra_code   <= cfg_data_i;
        default:         cfg_q             <= cfg_q;
      endcase
    end
  end

  rfpp_hdr_parse #(
    .DIM_BITS (DIM_BITS)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (in_i.data_byte),
    .eof_i       (in_i.end_of_frame),
    .cfg_i       (cfg_q),
    .res_valid_o (raw_valid),
    .res_o       (raw)
  );

  rfpp_pix_unpack u_unpack (
    .raw_i (raw),
    .pix_o (pix)
  );

  rfpp_out_skid u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (raw_valid),
    .res_i       (pix),
    .room_o      (room),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire
